FILE: rtl/jac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants of the seven-point Jacobi sweep: voxel and size
// widths, register indexes, the neighbor set and the per-voxel flags.
// ----------------------------------------------------------------------------
package jac_pkg;

   localparam int VAL_W   = 31;   // voxel value width
   localparam int DIM_W   = 7;    // grid size registers and coordinates
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W   = VAL_W + 3;   // sum of six voxels

   // Divide by six as (sum / 2) / 3, the divide by three done with a
   // reciprocal: (2^33 + 1) / 3 is exact for every 33-bit dividend.
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 33;
   localparam logic [RECIP_W-1:0] RECIP3 = 32'd2863311531;
   localparam int PROD_W = SUM_W - 1 + RECIP_W;

   localparam logic [DIM_W-1:0] DIM_FLOOR = 7'd3;
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_DEPTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] depth;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] width;
   } grid_dims_type;

   // The centre voxel and its six face neighbors.
   typedef struct packed {
      logic [VAL_W-1:0] zp;
      logic [VAL_W-1:0] yp;
      logic [VAL_W-1:0] xp;
      logic [VAL_W-1:0] center;
      logic [VAL_W-1:0] xm;
      logic [VAL_W-1:0] ym;
      logic [VAL_W-1:0] zm;
   } tap_set_type;

   typedef struct packed {
      logic on_boundary;
      logic sweep_last;
   } voxel_flags_type;

endpackage : jac_pkg
`default_nettype wire

FILE: rtl/jac_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jac_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module jac_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : jac_ram
`default_nettype wire

FILE: rtl/jac_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jac_window
// Sliding window of two planes plus one voxel, built as a chain of delay
// lines in RAM and two tap registers. Every shift pushes one voxel in and
// presents the centre voxel and its six face neighbors.
// ----------------------------------------------------------------------------
module jac_window #(
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WIDTH  = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       restart,
   input  wire logic                       shift,
   input  wire logic [jac_pkg::VAL_W-1:0]  shift_value,
   input  jac_pkg::grid_dims_type          dims,
   output jac_pkg::tap_set_type            taps
);

   localparam int DW    = jac_pkg::DIM_W;
   localparam int VW    = jac_pkg::VAL_W;
   // Sizes never exceed what the 7-bit registers can hold.
   localparam int EFF_H = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
   localparam int EFF_W = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
   // Plane minus one row, and one row minus one voxel.
   localparam int DEPTH_PL = EFF_W * (EFF_H - 1);
   localparam int DEPTH_RW = EFF_W - 1;
   localparam int PL_AW    = (DEPTH_PL > 1) ? $clog2(DEPTH_PL) : 1;
   localparam int RW_AW    = (DEPTH_RW > 1) ? $clog2(DEPTH_RW) : 1;

   logic [PL_AW-1:0] ptr_pl_ff, ptr_pl_in;
   logic [DW-1:0]    col_ff, col_in;
   logic [DW-1:0]    row_ff, row_in;
   logic [RW_AW-1:0] ptr_rw_ff, ptr_rw_in;
   logic [VW-1:0]    center_ff, center_in;
   logic [VW-1:0]    xm_ff, xm_in;
   logic [VW-1:0]    a_rd, b_rd, c_rd, d_rd;

   // The plane-sized lines wrap after (height - 1) rows of width voxels,
   // tracked with a column and row count so that no product is needed.
   always_comb begin
      ptr_pl_in = ptr_pl_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      ptr_rw_in = ptr_rw_ff;
      if (restart) begin
         ptr_pl_in = '0;
         col_in    = '0;
         row_in    = '0;
         ptr_rw_in = '0;
      end else if (shift) begin
         if (col_ff == dims.width - DW'(1)) begin
            col_in = '0;
            if (row_ff == dims.height - DW'(2)) begin
               row_in    = '0;
               ptr_pl_in = '0;
            end else begin
               row_in    = row_ff + DW'(1);
               ptr_pl_in = ptr_pl_ff + PL_AW'(1);
            end
         end else begin
            col_in    = col_ff + DW'(1);
            ptr_pl_in = ptr_pl_ff + PL_AW'(1);
         end
         if (DW'(ptr_rw_ff) == dims.width - DW'(2)) begin
            ptr_rw_in = '0;
         end else begin
            ptr_rw_in = ptr_rw_ff + RW_AW'(1);
         end
      end
   end

   always_comb begin
      center_in = center_ff;
      xm_in     = xm_ff;
      if (shift) begin
         center_in = b_rd;
         xm_in     = center_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_pl_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         ptr_rw_ff <= '0;
      end else begin
         ptr_pl_ff <= ptr_pl_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ptr_rw_ff <= ptr_rw_in;
      end
   end

   always_ff @(posedge clock) begin
      center_ff <= center_in;
      xm_ff     <= xm_in;
   end

   // Each line reads ahead at the next pointer, so its registered output is
   // the oldest entry, the one overwritten at the next shift.
   jac_ram #(.WIDTH(VW), .DEPTH(DEPTH_PL)) u_line_a (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (ptr_pl_ff),
      .wr_data (shift_value),
      .rd_addr (ptr_pl_in),
      .rd_data (a_rd)
   );

   jac_ram #(.WIDTH(VW), .DEPTH(DEPTH_RW)) u_line_b (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (ptr_rw_ff),
      .wr_data (a_rd),
      .rd_addr (ptr_rw_in),
      .rd_data (b_rd)
   );

   jac_ram #(.WIDTH(VW), .DEPTH(DEPTH_RW)) u_line_c (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (ptr_rw_ff),
      .wr_data (xm_ff),
      .rd_addr (ptr_rw_in),
      .rd_data (c_rd)
   );

   jac_ram #(.WIDTH(VW), .DEPTH(DEPTH_PL)) u_line_d (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (ptr_pl_ff),
      .wr_data (c_rd),
      .rd_addr (ptr_pl_in),
      .rd_data (d_rd)
   );

   assign taps.zp     = shift_value;
   assign taps.yp     = a_rd;
   assign taps.xp     = b_rd;
   assign taps.center = center_ff;
   assign taps.xm     = xm_ff;
   assign taps.ym     = c_rd;
   assign taps.zm     = d_rd;

   row_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      DW'(ptr_rw_ff) <= dims.width - DW'(2))
      else $error("row delay pointer beyond the row length");

endmodule : jac_window
`default_nettype wire

FILE: rtl/jac_mean.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jac_mean
// Three-register pipeline: neighbor capture, six-way sum, divide by six and
// boundary select into the result register.
// ----------------------------------------------------------------------------
module jac_mean (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       job_valid,
   input  jac_pkg::tap_set_type            job_taps,
   input  jac_pkg::voxel_flags_type        job_flags,
   output logic                            job_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [jac_pkg::VAL_W-1:0]       rsp_smoothed_value,
   output logic                            rsp_on_boundary,
   output logic                            rsp_sweep_last
);

   localparam int VW = jac_pkg::VAL_W;
   localparam int SW = jac_pkg::SUM_W;
   localparam int PW = jac_pkg::PROD_W;
   localparam int RS = jac_pkg::RECIP_SHIFT;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic rdy1, rdy2, rdy3;
   logic load2, load3;

   jac_pkg::tap_set_type     taps1_ff;
   jac_pkg::voxel_flags_type flags1_ff, flags2_ff, flags3_ff;
   logic [SW-1:0]            sum_ff, sum_in;
   logic [VW-1:0]            center2_ff;
   logic [VW-1:0]            value3_ff, value3_in;
   logic [SW-2:0]            half;
   logic [PW-1:0]            prod;

   assign rdy3      = !v3_ff || !rsp_stall;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign job_ready = rdy1;
   assign load2     = v1_ff && rdy2;
   assign load3     = v2_ff && rdy3;

   assign v1_in = job_valid || (v1_ff && !rdy2);
   assign v2_in = load2 || (v2_ff && !rdy3);
   assign v3_in = load3 || (v3_ff && rsp_stall);

   assign sum_in = SW'(taps1_ff.zp) + SW'(taps1_ff.yp) + SW'(taps1_ff.xp)
                 + SW'(taps1_ff.xm) + SW'(taps1_ff.ym) + SW'(taps1_ff.zm);

   assign half = sum_ff[SW-1:1];
   assign prod = PW'(half) * PW'(jac_pkg::RECIP3);

   assign value3_in = flags2_ff.on_boundary ? center2_ff : prod[RS+VW-1:RS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid) begin
         taps1_ff  <= job_taps;
         flags1_ff <= job_flags;
      end
      if (load2) begin
         sum_ff     <= sum_in;
         center2_ff <= taps1_ff.center;
         flags2_ff  <= flags1_ff;
      end
      if (load3) begin
         value3_ff <= value3_in;
         flags3_ff <= flags2_ff;
      end
   end

   assign rsp_valid          = v3_ff;
   assign rsp_smoothed_value = value3_ff;
   assign rsp_on_boundary    = flags3_ff.on_boundary;
   assign rsp_sweep_last     = flags3_ff.sweep_last;

   stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !job_ready |-> (v1_ff && v2_ff && v3_ff))
      else $error("pipeline refused a job with a free stage");

endmodule : jac_mean
`default_nettype wire

FILE: rtl/jacobi_seven_point_sweep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_seven_point_sweep
// One Jacobi sweep of a 3-D grid with a seven-point stencil over a stream.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on both sides, sustained, stalls permitting.
// Results: the result for a voxel is started when the word one plane later
// is accepted, and passes the neighbor capture, sum and divide registers.
// Reset: sweep counters clear and the grid sizes return to 64 (capped at the
// size limits); the window RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
//
// Voxels arrive in raster order, x fastest. The window is a chain of delay
// lines in RAM: one of (plane - row) voxels, one of (row - 1), two voxel
// registers, another of (row - 1) and another of (plane - row). When word t
// is accepted, the taps along that chain hold voxel p = t - plane and its six
// face neighbors, so the result for p is started in the same cycle.
//
// A word that is accepted as the first of a sweep with drain set is dropped.
// A drain word while voxels are still expected enters the window as zero,
// and so does any word after the whole grid has been taken. After the word
// whose result carries sweep_last, all counts clear and a new sweep begins.
//
// A configuration write to a known register sets the size, clamped to three
// up to the size limit, and restarts the sweep. Writes are taken at once.
module jacobi_seven_point_sweep #(
   parameter int MAX_DEPTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WIDTH  = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input words.
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [jac_pkg::VAL_W-1:0]       req_voxel_value,
   input  wire logic                            req_drain,
   // Result words.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [jac_pkg::VAL_W-1:0]            rsp_smoothed_value,
   output logic                                 rsp_on_boundary,
   output logic                                 rsp_sweep_last,
   // Configuration writes.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [jac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [jac_pkg::DIM_W-1:0]       csr_data
);

   localparam int DW = jac_pkg::DIM_W;
   localparam int VW = jac_pkg::VAL_W;

   // The 7-bit size registers cannot exceed 127 whatever the limit.
   localparam int EFF_D = (MAX_DEPTH < 127) ? MAX_DEPTH : 127;
   localparam int EFF_H = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
   localparam int EFF_W = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
   localparam logic [DW-1:0] CAP_D = DW'(EFF_D);
   localparam logic [DW-1:0] CAP_H = DW'(EFF_H);
   localparam logic [DW-1:0] CAP_W = DW'(EFF_W);
   localparam logic [DW-1:0] RST_D = (jac_pkg::DIM_RESET > CAP_D) ? CAP_D : jac_pkg::DIM_RESET;
   localparam logic [DW-1:0] RST_H = (jac_pkg::DIM_RESET > CAP_H) ? CAP_H : jac_pkg::DIM_RESET;
   localparam logic [DW-1:0] RST_W = (jac_pkg::DIM_RESET > CAP_W) ? CAP_W : jac_pkg::DIM_RESET;

   function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] value,
                                                input logic [DW-1:0] cap);
      logic [DW-1:0] result;
      result = value;
      if (result < jac_pkg::DIM_FLOOR) begin
         result = jac_pkg::DIM_FLOOR;
      end
      if (result > cap) begin
         result = cap;
      end
      return result;
   endfunction

   jac_pkg::grid_dims_type   dims_ff, dims_in;
   jac_pkg::tap_set_type     taps;
   jac_pkg::voxel_flags_type flags;

   // Input side position (voxel t) and output side position (voxel p).
   logic [DW-1:0] ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic [DW-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;

   logic          csr_hit, cfg_write;
   logic          req_accept, sweep_start, drop_word, shift;
   logic          past_grid, gives_result, job_ready;
   logic [VW-1:0] shift_value;

   // ---------------------------------------------------------------------
   // Configuration.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready;
   assign cfg_write = csr_hit && ((csr_index == jac_pkg::CSR_GRID_DEPTH) ||
                                  (csr_index == jac_pkg::CSR_GRID_HEIGHT) ||
                                  (csr_index == jac_pkg::CSR_GRID_WIDTH));

   always_comb begin
      dims_in = dims_ff;
      if (csr_hit) begin
         case (csr_index)
            jac_pkg::CSR_GRID_DEPTH:  dims_in.depth  = clamp_dim(csr_data, CAP_D);
            jac_pkg::CSR_GRID_HEIGHT: dims_in.height = clamp_dim(csr_data, CAP_H);
            jac_pkg::CSR_GRID_WIDTH:  dims_in.width  = clamp_dim(csr_data, CAP_W);
            default:                  dims_in = dims_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input acceptance. The stall comes straight from the pipeline, so a
   // word is taken in every cycle in which the last stage can move.
   // ---------------------------------------------------------------------
   assign req_stall    = !job_ready;
   assign req_accept   = req_valid && !req_stall;
   assign sweep_start  = (ix_ff == '0) && (iy_ff == '0) && (iz_ff == '0);
   assign drop_word    = req_drain && sweep_start;
   assign shift        = req_accept && !drop_word;
   assign past_grid    = (iz_ff == dims_ff.depth);
   assign shift_value  = (req_drain || past_grid) ? '0 : req_voxel_value;
   // The first plane only fills the window; after it every word gives one.
   assign gives_result = shift && (iz_ff != '0);

   assign flags.on_boundary = (ox_ff == '0) || (ox_ff == dims_ff.width - DW'(1)) ||
                              (oy_ff == '0) || (oy_ff == dims_ff.height - DW'(1)) ||
                              (oz_ff == '0) || (oz_ff == dims_ff.depth - DW'(1));
   assign flags.sweep_last  = (ox_ff == dims_ff.width - DW'(1)) &&
                              (oy_ff == dims_ff.height - DW'(1)) &&
                              (oz_ff == dims_ff.depth - DW'(1));

   // ---------------------------------------------------------------------
   // Sweep position counters.
   // ---------------------------------------------------------------------
   always_comb begin
      ix_in = ix_ff;
      iy_in = iy_ff;
      iz_in = iz_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oz_in = oz_ff;
      if (cfg_write || (gives_result && flags.sweep_last)) begin
         ix_in = '0;
         iy_in = '0;
         iz_in = '0;
         ox_in = '0;
         oy_in = '0;
         oz_in = '0;
      end else if (shift) begin
         // The input position stops once the whole grid has been taken.
         if (!past_grid) begin
            if (ix_ff == dims_ff.width - DW'(1)) begin
               ix_in = '0;
               if (iy_ff == dims_ff.height - DW'(1)) begin
                  iy_in = '0;
                  iz_in = iz_ff + DW'(1);
               end else begin
                  iy_in = iy_ff + DW'(1);
               end
            end else begin
               ix_in = ix_ff + DW'(1);
            end
         end
         if (gives_result) begin
            if (ox_ff == dims_ff.width - DW'(1)) begin
               ox_in = '0;
               if (oy_ff == dims_ff.height - DW'(1)) begin
                  oy_in = '0;
                  oz_in = oz_ff + DW'(1);
               end else begin
                  oy_in = oy_ff + DW'(1);
               end
            end else begin
               ox_in = ox_ff + DW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.depth  <= RST_D;
         dims_ff.height <= RST_H;
         dims_ff.width  <= RST_W;
         ix_ff <= '0;
         iy_ff <= '0;
         iz_ff <= '0;
         ox_ff <= '0;
         oy_ff <= '0;
         oz_ff <= '0;
      end else begin
         dims_ff <= dims_in;
         ix_ff   <= ix_in;
         iy_ff   <= iy_in;
         iz_ff   <= iz_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         oz_ff   <= oz_in;
      end
   end

   // ---------------------------------------------------------------------
   // Window and arithmetic.
   // ---------------------------------------------------------------------
   jac_window #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .restart     (cfg_write),
      .shift       (shift),
      .shift_value (shift_value),
      .dims        (dims_ff),
      .taps        (taps)
   );

   jac_mean u_mean (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (gives_result),
      .job_taps           (taps),
      .job_flags          (flags),
      .job_ready          (job_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_on_boundary    (rsp_on_boundary),
      .rsp_sweep_last     (rsp_sweep_last)
   );

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------
   // While the first plane fills the window no result has been counted.
   first_plane_no_results: assert property (@(posedge clock) disable iff (reset)
      (iz_ff == '0) |-> ((ox_ff == '0) && (oy_ff == '0) && (oz_ff == '0)))
      else $error("result position moved during the first plane");

   // Once past the first plane, the output plane stays below the input plane.
   output_trails_input: assert property (@(posedge clock) disable iff (reset)
      (iz_ff != '0) |-> (oz_ff < iz_ff))
      else $error("output plane caught up with the input plane");

   // A size write restarts the sweep.
   cfg_restarts_sweep: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> ((ix_ff == '0) && (iy_ff == '0) && (iz_ff == '0) &&
                     (ox_ff == '0) && (oy_ff == '0) && (oz_ff == '0)))
      else $error("sweep counters not cleared by a size write");

endmodule : jacobi_seven_point_sweep
`default_nettype wire

FILE: tb/jacobi_seven_point_sweep_test.sv
// ----------------------------------------------------------------------------
// jacobi_seven_point_sweep_test
// Self-checking bench for the seven-point Jacobi sweep. Grids of many sizes are
// streamed in raster order and flushed with one more plane of words. Every
// result word is compared with the output of a behavioral model of the sweep
// that runs beside the block.
// ----------------------------------------------------------------------------
module jacobi_seven_point_sweep_test;
   timeunit 1ns;
   timeprecision 1ps;

   import jac_pkg::*;

   localparam int MAX_DEPTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_WIDTH  = 64;

   // The window holds two planes plus one voxel of the largest grid.
   localparam int unsigned WIN_DEPTH = 2 * MAX_HEIGHT * MAX_WIDTH + 1;
   localparam int NEIGHBOR_COUNT = 6;

   localparam logic [VAL_W-1:0] VAL_MAX = '1;
   localparam logic [VAL_W-1:0] ALT_A   = 31'h5555_5555;
   localparam logic [VAL_W-1:0] ALT_B   = 31'h2AAA_AAAA;

   // Index 3 maps to no register. A write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int NO_CUT         = 32'h7FFF_FFFF;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int TAIL_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 50;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             on_boundary;
      logic             sweep_last;
   } smoothed_voxel_t;

   // Clock, reset and every input of the block start at known values.
   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [VAL_W-1:0]     req_voxel_value = '0;
   logic                 req_drain = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VAL_W-1:0]     rsp_smoothed_value;
   logic                 rsp_on_boundary;
   logic                 rsp_sweep_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_data = '0;

   // Pacing of both channels, in percent of cycles.
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   int error_count = 0;
   int idle_cycles = 0;

   // Grid size as the stimulus side believes it to be, used to shape sweeps.
   int unsigned plan_z, plan_y, plan_x;

   // Model state: the voxel ring, the two sweep counters and the grid size.
   logic [VAL_W-1:0] window_mem [WIN_DEPTH];
   int unsigned      taken_cnt, given_cnt;
   int unsigned      dim_z, dim_y, dim_x;

   // Smoothed voxels that the block still owes, oldest first.
   smoothed_voxel_t smoothed_q [$];

   jacobi_seven_point_sweep #(
      .MAX_DEPTH  (MAX_DEPTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WIDTH  (MAX_WIDTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_voxel_value    (req_voxel_value),
      .req_drain          (req_drain),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_on_boundary    (rsp_on_boundary),
      .rsp_sweep_last     (rsp_sweep_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral model of the sweep
   // ------------------------------------------------------------------------

   // A size register holds three up to the size limit; anything else is
   // pulled to the nearer bound.
   function automatic int unsigned clamp_size(input logic [DIM_W-1:0] raw,
                                              input int unsigned limit);
      int unsigned size;
      size = raw;
      if (size < DIM_FLOOR) size = DIM_FLOOR;
      if (size > limit) size = limit;
      return size;
   endfunction

   function automatic longint unsigned window_at(input int unsigned pos);
      return window_mem[pos % WIN_DEPTH];
   endfunction

   // Takes one accepted input word and returns 1 with the smoothed voxel when
   // that word lets a voxel leave. A voxel leaves one plane after it came in,
   // which is when its upper neighbor in z has just been stored.
   function automatic bit jacobi_step(input logic [VAL_W-1:0] value,
                                      input logic drain,
                                      output smoothed_voxel_t res);
      int unsigned       plane, total, pos, x, y, z;
      longint unsigned   sum;
      bit                face;
      plane = dim_y * dim_x;
      total = dim_z * plane;
      res = '0;
      // Drain words between sweeps carry nothing and start nothing.
      if (drain && taken_cnt == 0) return 1'b0;
      // Drain words inside the grid count as zero voxels, and anything past
      // the grid is only a flush word.
      if (taken_cnt < total) window_mem[taken_cnt % WIN_DEPTH] = drain ? '0 : value;
      taken_cnt++;
      if (taken_cnt <= plane) return 1'b0;

      pos = given_cnt;
      x = pos % dim_x;
      y = (pos / dim_x) % dim_y;
      z = pos / plane;
      face = x == 0 || x == dim_x - 1 || y == 0 || y == dim_y - 1 ||
             z == 0 || z == dim_z - 1;
      if (face) begin
         res.value = window_mem[pos % WIN_DEPTH];
      end else begin
         sum = window_at(pos + 1) + window_at(pos - 1) +
               window_at(pos + dim_x) + window_at(pos - dim_x) +
               window_at(pos + plane) + window_at(pos - plane);
         res.value = VAL_W'(sum / NEIGHBOR_COUNT);
      end
      res.on_boundary = face;
      res.sweep_last  = pos + 1 >= total;
      if (res.sweep_last) begin
         taken_cnt = 0;
         given_cnt = 0;
      end else begin
         given_cnt = pos + 1;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      // Past a few dozen reports the rest are only counted.
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Everything is sampled at the rising edge, before any of the nonblocking
   // updates of that edge land, so the view matches what the block saw.
   always @(posedge clock) begin : sweep_scoreboard
      smoothed_voxel_t want;
      bit              restart;
      if (reset) begin
         taken_cnt = 0;
         given_cnt = 0;
         dim_z = clamp_size(DIM_RESET, MAX_DEPTH);
         dim_y = clamp_size(DIM_RESET, MAX_HEIGHT);
         dim_x = clamp_size(DIM_RESET, MAX_WIDTH);
         smoothed_q.delete();
      end else begin
         // A write to a known size register takes effect at once and starts
         // the sweep over.
         if (csr_valid && csr_ready) begin
            restart = 1'b1;
            case (csr_index)
               CSR_GRID_DEPTH:  dim_z = clamp_size(csr_data, MAX_DEPTH);
               CSR_GRID_HEIGHT: dim_y = clamp_size(csr_data, MAX_HEIGHT);
               CSR_GRID_WIDTH:  dim_x = clamp_size(csr_data, MAX_WIDTH);
               default:         restart = 1'b0;
            endcase
            if (restart) begin
               taken_cnt = 0;
               given_cnt = 0;
            end
         end
         if (req_valid && !req_stall) begin
            if (jacobi_step(req_voxel_value, req_drain, want)) smoothed_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (smoothed_q.size() == 0) begin
               report_mismatch("result word with none expected", rsp_smoothed_value, 0);
            end else begin
               want = smoothed_q.pop_front();
               if (rsp_smoothed_value !== want.value)
                  report_mismatch("smoothed_value", rsp_smoothed_value, want.value);
               if (rsp_on_boundary !== want.on_boundary)
                  report_mismatch("on_boundary", rsp_on_boundary, want.on_boundary);
               if (rsp_sweep_last !== want.sweep_last)
                  report_mismatch("sweep_last", rsp_sweep_last, want.sweep_last);
            end
         end
      end
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Ends the run when no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic set_pace(input int sender_pct, input int stall_pct);
      sender_idle_pct = sender_pct;
      rsp_stall_pct   = stall_pct;
   endtask

   // Zero and all ones are favored, since they bound the six-voxel sum.
   function automatic logic [VAL_W-1:0] random_voxel();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(7))
         0:       return '0;
         1:       return VAL_MAX;
         default: return raw[VAL_W-1:0];
      endcase
   endfunction

   // Mostly small sides; now and then a value below the floor or a longer one.
   function automatic logic [DIM_W-1:0] random_size();
      case ($urandom_range(9))
         0:       return DIM_W'($urandom_range(2));
         1:       return DIM_W'($urandom_range(7, 10));
         default: return DIM_W'($urandom_range(3, 6));
      endcase
   endfunction

   // Offers one input word after a random idle gap and returns at the edge
   // where it is taken. Valid stays high so a following word can go out
   // back to back.
   task automatic send_word(input logic [VAL_W-1:0] value, input logic drain);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_voxel_value <= value;
      req_drain       <= drain;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Leaves csr_valid high, so writes can follow one another without a gap;
   // end_csr_writes drops it.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_GRID_DEPTH:  plan_z = clamp_size(value, MAX_DEPTH);
         CSR_GRID_HEIGHT: plan_y = clamp_size(value, MAX_HEIGHT);
         CSR_GRID_WIDTH:  plan_x = clamp_size(value, MAX_WIDTH);
         default: ;
      endcase
   endtask

   task automatic end_csr_writes();
      csr_valid <= 1'b0;
   endtask

   // Stops sending and waits until every owed voxel has come out. The tail
   // covers words of the first plane, which are still in flight inside the
   // block with nothing owed for them.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (smoothed_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // One sweep of the planned grid with random voxels: optional drain words
   // before it (dropped by the block), early drain words inside the grid,
   // and a flush plane in which some words may carry data. cut_after ends
   // the sweep early after that many words.
   task automatic send_sweep(input int lead_drains, input int early_pct,
                             input int late_pct, input int cut_after, output int sent);
      int unsigned plane, total;
      bit          drain;
      plane = plan_y * plan_x;
      total = plan_z * plane;
      sent = 0;
      repeat (lead_drains) send_word(random_voxel(), 1'b1);
      for (int unsigned i = 0; i < total + plane && i < cut_after; i++) begin
         // The first voxel of a sweep is never a drain word, or the sweep
         // would not start there.
         if (i < total) drain = i != 0 && $urandom_range(99) < early_pct;
         else drain = !($urandom_range(99) < late_pct);
         send_word(random_voxel(), drain);
         sent++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Leaves the width at its reset value of 64 and pulls depth and height up
   // from below the floor. The unmapped index must not disturb anything.
   task automatic test_reset_sizes();
      int sent;
      set_pace(22, 22);
      write_csr(CSR_GRID_DEPTH, 7'd0);
      write_csr(CSR_GRID_HEIGHT, 7'd2);
      write_csr(CSR_UNMAPPED, 7'd127);
      end_csr_writes();
      send_sweep(2, 0, 0, NO_CUT, sent);
      wait_drained();
   endtask

   // A 3x3x3 grid has one interior voxel, at index 13. Its neighbors are set
   // so that five hold the largest value and the upper one in z is an early
   // drain word, which gives a wide sum and a truncated mean. The faces cycle
   // through zero, all ones and the two alternating bit patterns. A second
   // early drain word sits on a face, and the flush plane begins with data.
   task automatic test_corner_values();
      logic [VAL_W-1:0] pattern [4];
      logic [VAL_W-1:0] value;
      bit               drain;
      pattern = '{'0, VAL_MAX, ALT_A, ALT_B};
      set_pace(0, 0);
      write_csr(CSR_GRID_DEPTH, 7'd3);
      write_csr(CSR_GRID_HEIGHT, 7'd3);
      write_csr(CSR_GRID_WIDTH, 7'd3);
      end_csr_writes();
      // Drain words while no sweep is under way are dropped.
      send_word(VAL_MAX, 1'b1);
      send_word('0, 1'b1);
      for (int i = 0; i < 27; i++) begin
         value = pattern[i % 4];
         drain = 1'b0;
         case (i)
            4, 10, 12, 14, 16: value = VAL_MAX;
            5, 22:             drain = 1'b1;
            default: ;
         endcase
         send_word(value, drain);
      end
      // Data words after the grid only flush the window.
      for (int i = 0; i < 9; i++) send_word(random_voxel(), i >= 3);
      wait_drained();
   endtask

   // Abandons a sweep a few voxels into its second plane. Rewriting the width
   // with the same value must restart the count, so the next full sweep
   // lines up from its first word.
   task automatic test_restart_on_write();
      int sent;
      set_pace(22, 22);
      write_csr(CSR_GRID_DEPTH, 7'd4);
      write_csr(CSR_GRID_HEIGHT, 7'd3);
      write_csr(CSR_GRID_WIDTH, 7'd5);
      end_csr_writes();
      send_sweep(0, 0, 0, plan_y * plan_x + 7, sent);
      wait_drained();
      write_csr(CSR_GRID_WIDTH, 7'd5);
      end_csr_writes();
      send_sweep(1, 10, 30, NO_CUT, sent);
      wait_drained();
   endtask

   // Depth at its limit, reached by a write above it, then height written at
   // exactly the limit. The other sides stay at three to keep the grids short.
   task automatic test_size_extremes();
      int sent;
      set_pace(0, 78);
      write_csr(CSR_GRID_WIDTH, 7'd2);
      write_csr(CSR_GRID_DEPTH, 7'd127);
      end_csr_writes();
      send_sweep(1, 3, 50, NO_CUT, sent);
      wait_drained();
      set_pace(78, 0);
      write_csr(CSR_GRID_DEPTH, 7'd3);
      write_csr(CSR_GRID_HEIGHT, 7'd64);
      end_csr_writes();
      send_sweep(0, 0, 100, NO_CUT, sent);
      wait_drained();
   endtask

   // Random small grids under all four pacing phases. Most sweeps are whole;
   // about one in ten is cut short and followed by a restarting write.
   task automatic test_random_sweeps();
      int sent, total_sent, sweep_no, cut, early_pct, late_pct;
      total_sent = 0;
      sweep_no = 0;
      while (total_sent < RANDOM_ITEMS) begin
         case (sweep_no % 4)
            0:       set_pace(0, 0);
            1:       set_pace(78, 0);
            2:       set_pace(0, 78);
            default: set_pace(22, 22);
         endcase
         if (sweep_no == 0 || $urandom_range(1) == 0) begin
            write_csr(CSR_GRID_DEPTH, random_size());
            write_csr(CSR_GRID_HEIGHT, random_size());
            write_csr(CSR_GRID_WIDTH, random_size());
            end_csr_writes();
         end
         cut = NO_CUT;
         if ($urandom_range(9) == 0)
            cut = $urandom_range(1, (plan_z + 1) * plan_y * plan_x - 1);
         early_pct = ($urandom_range(3) == 0) ? 5 : 0;
         case ($urandom_range(2))
            0:       late_pct = 0;
            1:       late_pct = 30;
            default: late_pct = 100;
         endcase
         send_sweep($urandom_range(2), early_pct, late_pct, cut, sent);
         total_sent += sent;
         wait_drained();
         if (cut != NO_CUT) begin
            write_csr(CSR_GRID_WIDTH, DIM_W'(plan_x));
            end_csr_writes();
         end
         sweep_no++;
      end
   endtask

   initial begin
      plan_z = clamp_size(DIM_RESET, MAX_DEPTH);
      plan_y = clamp_size(DIM_RESET, MAX_HEIGHT);
      plan_x = clamp_size(DIM_RESET, MAX_WIDTH);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_sizes();
      test_corner_values();
      test_restart_on_write();
      test_size_extremes();
      test_random_sweeps();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule : jacobi_seven_point_sweep_test
